[rtl/swmm_pkg.sv]
// Shared constants, types and state encoding for the sliding-window min/max/mean block.
`timescale 1ns / 1ps

package swmm_pkg;

  localparam int DATA_W = 16;
  localparam int WINDOW = 100;
  localparam int AW     = $clog2(WINDOW);

  // Sum of WINDOW full-scale samples
  localparam int SUM_W = $clog2(WINDOW * ((1 << DATA_W) - 1) + 1);

  // floor(sum / WINDOW) = (sum * RECIP) >> RECIP_SH, exact for any sum below 2**SUM_W
  localparam int RECIP_SH = SUM_W + $clog2(WINDOW);
  localparam int RECIP_W  = SUM_W + 1;
  localparam longint unsigned RECIP_VAL =
    ((64'd1 << RECIP_SH) + 64'(WINDOW) - 64'd1) / 64'(WINDOW);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_VAL);
  localparam int PROD_W = SUM_W + RECIP_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DRAIN,
    ST_MUL,
    ST_DONE
  } state_t;

  typedef struct packed {
    logic wr;
    logic scan;
    logic mul;
    logic ld_out;
  } dp_cmd_t;

  typedef struct packed {
    logic scan_last;
  } dp_stat_t;

endpackage

[rtl/swmm_ctrl.sv]
// Controller state machine: sequences write, ring scan, mean multiply and result load.
`timescale 1ns / 1ps

module swmm_ctrl (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  output logic               out_valid,
  input  logic               out_ready,
  input  swmm_pkg::dp_stat_t stat,
  output swmm_pkg::dp_cmd_t  cmd
);

  swmm_pkg::state_t state_r;
  swmm_pkg::state_t state_nxt;
  logic             out_valid_r;
  logic             out_valid_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= swmm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_comb begin
    state_nxt     = state_r;
    cmd           = '0;
    in_ready      = 1'b0;
    out_valid_nxt = out_valid_r;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    unique case (state_r)
      swmm_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.wr    = 1'b1;
          state_nxt = swmm_pkg::ST_SCAN;
        end
      end
      swmm_pkg::ST_SCAN: begin
        cmd.scan = 1'b1;
        if (stat.scan_last) begin
          state_nxt = swmm_pkg::ST_DRAIN;
        end
      end
      swmm_pkg::ST_DRAIN: begin
        state_nxt = swmm_pkg::ST_MUL;
      end
      swmm_pkg::ST_MUL: begin
        cmd.mul   = 1'b1;
        state_nxt = swmm_pkg::ST_DONE;
      end
      swmm_pkg::ST_DONE: begin
        // hold until the output register is free
        if (!out_valid_r || out_ready) begin
          cmd.ld_out    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = swmm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = swmm_pkg::ST_IDLE;
      end
    endcase
  end

  assign out_valid = out_valid_r;

endmodule

[rtl/swmm_dp.sv]
// Datapath: sample ring memory, scan accumulators, reciprocal multiply and result registers.
`timescale 1ns / 1ps

module swmm_dp (
  input  logic                        clk,
  input  logic                        rst_n,
  input  swmm_pkg::dp_cmd_t           cmd,
  output swmm_pkg::dp_stat_t          stat,
  input  logic [swmm_pkg::DATA_W-1:0] in_sample,
  output logic [swmm_pkg::DATA_W-1:0] out_window_min,
  output logic [swmm_pkg::DATA_W-1:0] out_window_max,
  output logic [swmm_pkg::DATA_W-1:0] out_window_mean
);

  logic [swmm_pkg::DATA_W-1:0] ring_mem [swmm_pkg::WINDOW];
  logic [swmm_pkg::WINDOW-1:0] ent_vld_r;

  logic [swmm_pkg::AW-1:0]     wp_r;
  logic [swmm_pkg::AW-1:0]     scan_addr_r;
  logic [swmm_pkg::DATA_W-1:0] rd_data_r;
  logic                        rd_ok_r;
  logic                        rd_pend_r;
  logic [swmm_pkg::DATA_W-1:0] rd_val;

  logic [swmm_pkg::DATA_W-1:0] min_r;
  logic [swmm_pkg::DATA_W-1:0] max_r;
  logic [swmm_pkg::SUM_W-1:0]  sum_r;
  logic [swmm_pkg::PROD_W-1:0] prod_r;

  logic [swmm_pkg::DATA_W-1:0] out_min_r;
  logic [swmm_pkg::DATA_W-1:0] out_max_r;
  logic [swmm_pkg::DATA_W-1:0] out_mean_r;

  logic scan_last;

  assign scan_last      = (scan_addr_r == swmm_pkg::AW'(swmm_pkg::WINDOW - 1));
  assign stat.scan_last = scan_last;

  // Ring storage: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      ring_mem[wp_r] <= in_sample;
    end
    rd_data_r <= ring_mem[scan_addr_r];
  end

  // Entry valid bits stand in for clearing the ring at reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ent_vld_r <= '0;
      rd_ok_r   <= 1'b0;
      rd_pend_r <= 1'b0;
      wp_r      <= '0;
      scan_addr_r <= '0;
    end else begin
      rd_ok_r   <= ent_vld_r[scan_addr_r];
      rd_pend_r <= cmd.scan;
      if (cmd.wr) begin
        ent_vld_r[wp_r] <= 1'b1;
        scan_addr_r     <= '0;
        if (wp_r == swmm_pkg::AW'(swmm_pkg::WINDOW - 1)) begin
          wp_r <= '0;
        end else begin
          wp_r <= wp_r + 1'b1;
        end
      end else if (cmd.scan && !scan_last) begin
        scan_addr_r <= scan_addr_r + 1'b1;
      end
    end
  end

  assign rd_val = rd_ok_r ? rd_data_r : '0;

  always_ff @(posedge clk) begin
    if (cmd.wr) begin
      min_r <= '1;
      max_r <= '0;
      sum_r <= '0;
    end else if (rd_pend_r) begin
      if (rd_val < min_r) begin
        min_r <= rd_val;
      end
      if (rd_val > max_r) begin
        max_r <= rd_val;
      end
      sum_r <= sum_r + swmm_pkg::SUM_W'(rd_val);
    end
    if (cmd.mul) begin
      prod_r <= swmm_pkg::PROD_W'(sum_r) * swmm_pkg::PROD_W'(swmm_pkg::RECIP);
    end
    if (cmd.ld_out) begin
      out_min_r  <= min_r;
      out_max_r  <= max_r;
      out_mean_r <= prod_r[swmm_pkg::RECIP_SH +: swmm_pkg::DATA_W];
    end
  end

  assign out_window_min  = out_min_r;
  assign out_window_max  = out_max_r;
  assign out_window_mean = out_mean_r;

endmodule

[rtl/sliding_window_min_max_mean_top.sv]
// Top level of the sliding-window minimum, maximum and mean block.
`timescale 1ns / 1ps
//
// Usage:
//   Input channel (in_valid/in_ready/in_sample) takes one unsigned 8.8 fixed
//   point sample per transaction. The sample overwrites the oldest entry of a
//   100-entry ring; the whole ring is then scanned for min, max and sum.
//   Result channel (out_valid/out_ready/out_window_*) delivers one transaction
//   per accepted sample: ring minimum, maximum and floor(sum / 100).
//   The ring scan reads one entry per cycle through the single memory read
//   port. in_ready is high only while the controller is idle. A finished
//   result waits in the output register, so the next sample is taken while
//   it sits unclaimed; if the receiver stalls past the next scan, the
//   controller holds the new result until the output register frees up.
//   Reset (rst_n low, synchronous) clears the write position and all entry
//   valid bits, so never-written entries read as zero and count in the
//   minimum and the mean. No clearing pass is needed.
//

module sliding_window_min_max_mean_top (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        in_valid,
  output logic                        in_ready,
  input  logic [swmm_pkg::DATA_W-1:0] in_sample,
  output logic                        out_valid,
  input  logic                        out_ready,
  output logic [swmm_pkg::DATA_W-1:0] out_window_min,
  output logic [swmm_pkg::DATA_W-1:0] out_window_max,
  output logic [swmm_pkg::DATA_W-1:0] out_window_mean
);

  swmm_pkg::dp_cmd_t  dp_cmd;
  swmm_pkg::dp_stat_t dp_stat;

  // Sequence each transaction: write, scan, drain, multiply, load result
  swmm_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .stat      (dp_stat),
    .cmd       (dp_cmd)
  );

  // Hold the ring and compute the statistics
  swmm_dp u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (dp_cmd),
    .stat            (dp_stat),
    .in_sample       (in_sample),
    .out_window_min  (out_window_min),
    .out_window_max  (out_window_max),
    .out_window_mean (out_window_mean)
  );

  // Ring write happens only on an input transaction
  a_wr_on_accept : assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.wr |-> (in_valid && in_ready))
    else $error("ring written without an input transaction");

  // Every accepted sample starts a scan and blocks further input
  a_scan_after_accept : assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (dp_cmd.scan && !in_ready))
    else $error("scan did not start after input transaction");

  // A result load never overwrites an unclaimed result
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.ld_out |-> (!out_valid || out_ready))
    else $error("result register overwritten while still pending");

  // A loaded result is offered on the next cycle
  a_valid_after_load : assert property (@(posedge clk) disable iff (!rst_n)
    dp_cmd.ld_out |=> out_valid)
    else $error("out_valid missing after result load");

endmodule

[tb/tb_sliding_window_min_max_mean_top.sv]
// Self-checking testbench for the sliding-window minimum, maximum and mean block.
`timescale 1ns / 1ps

module tb_sliding_window_min_max_mean_top;

  localparam int DATA_W = swmm_pkg::DATA_W;
  localparam int WINDOW = swmm_pkg::WINDOW;

  // Give the run a generous ceiling to cover every item, plus long gaps on
  // both sides and one long receiver hold, taken several times over.
  localparam int CYCLE_LIMIT    = 1_500_000;
  // Make every settle pause a little longer than the time a result takes.
  localparam int DRAIN_CYCLES   = 110;
  // Hold the result channel long enough to span several scans.
  localparam int RX_HOLD_CYCLES = 800;
  localparam int RANDOM_ITEMS   = 600;

  typedef struct packed {
    logic [DATA_W-1:0] lo;
    logic [DATA_W-1:0] hi;
    logic [DATA_W-1:0] mean;
  } window_stats_t;

  typedef enum int {
    BURST_UNIFORM,
    BURST_LOW,
    BURST_HIGH,
    BURST_CONST,
    BURST_ONE_BIT
  } burst_kind_t;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  logic [DATA_W-1:0] in_sample = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [DATA_W-1:0] out_window_min;
  logic [DATA_W-1:0] out_window_max;
  logic [DATA_W-1:0] out_window_mean;

  // Shadow copy of the block's sample ring and write position.
  logic [DATA_W-1:0] ring_shadow [WINDOW];
  int unsigned       next_slot = 0;
  window_stats_t     expected_stats [$];

  int  err_count   = 0;
  int  cycle_count = 0;
  bit  tx_gaps_on  = 1'b1;  // only touched by the stimulus process
  bit  rx_gaps_on  = 1'b0;  // written with NBAs, read by the receiver process
  int  hold_req    = 0;
  int  hold_done   = 0;
  int  rx_wait     = 0;

  sliding_window_min_max_mean_top u_dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_sample       (in_sample),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_window_min  (out_window_min),
    .out_window_max  (out_window_max),
    .out_window_mean (out_window_mean)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Abort the run if it hangs.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // Pick an idle gap: mostly a few cycles, now and then a long one.
  function automatic int gap_len();
    if ($urandom_range(0, 15) == 0) begin
      return $urandom_range(20, 150);
    end
    return $urandom_range(1, 4);
  endfunction

  task automatic report_mismatch(input string msg);
    $display("MISMATCH at cycle %0d: %s", cycle_count, msg);
    err_count++;
  endtask

  // Write one sample into the shadow ring, rescan it and queue the
  // statistics that the block must return for this transaction.
  task automatic record_sample(input logic [DATA_W-1:0] value);
    window_stats_t stats;
    logic [31:0]   total;
    ring_shadow[next_slot] = value;
    next_slot = (next_slot + 1 >= WINDOW) ? 0 : next_slot + 1;
    stats.lo = '1;
    stats.hi = '0;
    total    = '0;
    for (int i = 0; i < WINDOW; i++) begin
      if (ring_shadow[i] < stats.lo) begin
        stats.lo = ring_shadow[i];
      end
      if (ring_shadow[i] > stats.hi) begin
        stats.hi = ring_shadow[i];
      end
      total += ring_shadow[i];
    end
    stats.mean = DATA_W'(total / WINDOW);
    expected_stats.push_back(stats);
  endtask

  // Offer one sample and hold it until the block takes it. Valid drops only
  // when a gap is inserted, so back-to-back transactions keep it high.
  task automatic send_sample(input logic [DATA_W-1:0] value);
    int gap;
    gap = tx_gaps_on ? gap_len() - 1 : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid  <= 1'b1;
    in_sample <= value;
    @(posedge clk);
    while (!in_ready) begin
      @(posedge clk);
    end
    record_sample(value);
  endtask

  // Stop offering, wait for every outstanding result, then let the block
  // settle so that a stray extra transaction would still be caught.
  task automatic wait_for_drain();
    in_valid <= 1'b0;
    while (expected_stats.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Receiver: a long hold when the stimulus asks for one, random stalls when
  // enabled, otherwise always ready.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      rx_wait   <= 0;
    end else if (rx_wait > 0) begin
      out_ready <= 1'b0;
      rx_wait   <= rx_wait - 1;
    end else if (hold_req != hold_done) begin
      out_ready <= 1'b0;
      rx_wait   <= RX_HOLD_CYCLES - 1;
      hold_done <= hold_req;
    end else if (rx_gaps_on && $urandom_range(0, 3) == 0) begin
      out_ready <= 1'b0;
      rx_wait   <= gap_len() - 1;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compare every accepted result against the oldest queued expectation.
  always @(posedge clk) begin
    window_stats_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_stats.size() == 0) begin
        report_mismatch($sformatf("unexpected result min=%h max=%h mean=%h",
                                  out_window_min, out_window_max, out_window_mean));
      end else begin
        want = expected_stats.pop_front();
        if (out_window_min !== want.lo) begin
          report_mismatch($sformatf("window_min got %h want %h", out_window_min, want.lo));
        end
        if (out_window_max !== want.hi) begin
          report_mismatch($sformatf("window_max got %h want %h", out_window_max, want.hi));
        end
        if (out_window_mean !== want.mean) begin
          report_mismatch($sformatf("window_mean got %h want %h",
                                    out_window_mean, want.mean));
        end
      end
    end
  end

  // Right after reset most of the ring still reads as zero, so the minimum
  // and mean must include those zeros. Drive the field extremes and
  // alternating bit patterns so every input bit toggles.
  task automatic test_partial_window();
    logic [DATA_W-1:0] pattern [12];
    pattern = '{16'hFFFF, 16'h0000, 16'h0001, 16'h8000, 16'h00FF, 16'hFF00,
                16'h5555, 16'hAAAA, 16'h7FFF, 16'hFFFE, 16'h0100, 16'hFFFF};
    tx_gaps_on = 1'b1;
    rx_gaps_on <= 1'b1;
    foreach (pattern[i]) begin
      send_sample(pattern[i]);
    end
    wait_for_drain();
  endtask

  // Fill the whole window with full scale: the mean must reach 65535 with no
  // wrap of the sum, and the minimum must finally leave zero. Run with no
  // idling on either side, and pass the write-position wrap.
  task automatic test_full_scale_window();
    tx_gaps_on = 1'b0;
    rx_gaps_on <= 1'b0;
    repeat (WINDOW + 5) begin
      send_sample(16'hFFFF);
    end
    wait_for_drain();
  endtask

  // Stall the result channel for a long stretch while the sender keeps
  // offering, so the output register and the controller both fill up and
  // the block must drop in_ready.
  task automatic test_result_backpressure();
    tx_gaps_on = 1'b0;
    rx_gaps_on <= 1'b0;
    hold_req <= hold_req + 1;
    repeat (12) begin
      send_sample(DATA_W'($urandom_range(0, 65535)));
    end
    wait_for_drain();
  endtask

  // Random bursts of one kind each; some are long enough to flood the
  // window, and idling is switched on and off per burst.
  task automatic test_random_bursts();
    burst_kind_t       kind;
    int                burst_len;
    int                sent;
    logic [DATA_W-1:0] const_val;
    logic [DATA_W-1:0] value;
    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      kind      = burst_kind_t'($urandom_range(0, 4));
      burst_len = ($urandom_range(0, 7) == 0) ? $urandom_range(WINDOW, WINDOW + 30)
                                              : $urandom_range(1, 30);
      const_val = DATA_W'($urandom_range(0, 65535));
      tx_gaps_on = ($urandom_range(0, 4) != 0);
      rx_gaps_on <= ($urandom_range(0, 4) != 0);
      repeat (burst_len) begin
        case (kind)
          BURST_LOW:     value = DATA_W'($urandom_range(0, 255));
          BURST_HIGH:    value = DATA_W'($urandom_range(65280, 65535));
          BURST_CONST:   value = const_val;
          BURST_ONE_BIT: value = DATA_W'(1) << $urandom_range(0, DATA_W - 1);
          default:       value = DATA_W'($urandom_range(0, 65535));
        endcase
        send_sample(value);
        sent++;
      end
    end
    wait_for_drain();
  endtask

  initial begin
    foreach (ring_shadow[i]) begin
      ring_shadow[i] = '0;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_partial_window();
    test_full_scale_window();
    test_result_backpressure();
    test_random_bursts();

    if (err_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule

[filelist.f]
rtl/swmm_pkg.sv
rtl/swmm_ctrl.sv
rtl/swmm_dp.sv
rtl/sliding_window_min_max_mean_top.sv
tb/tb_sliding_window_min_max_mean_top.sv
